[src/adaptive_pixel_predictor_select_assert.svh]
// Assertion macros for the adaptive pixel predictor select block.
`ifndef ADAPTIVE_PIXEL_PREDICTOR_SELECT_ASSERT_SVH
`define ADAPTIVE_PIXEL_PREDICTOR_SELECT_ASSERT_SVH
`ifndef SYNTHESIS
`define APS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aps: assertion failed");
`define APS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("aps: reset check failed");
`else
`define APS_ASSERT(lbl, prop)
`define APS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[src/aps_pkg.sv]
// Types, constants and predictor functions of the adaptive pixel predictor select block.
package aps_pkg;

  localparam int PIX_W  = 8;
  localparam int IDX_W  = 4;
  localparam int PRED_W = 10;
  localparam int ERR_W  = 10;
  localparam int WORD_W = IDX_W + PIX_W;
  localparam int CFG_W  = 13;

  localparam logic [IDX_W-1:0] USED_MEDIAN = 4'd13;
  localparam logic [IDX_W-1:0] USED_NONE   = 4'd14;
  localparam logic [ERR_W-1:0] ERR_INIT    = 10'd1000;

  localparam logic [CFG_W-1:0] WIDTH_RST = 13'd512;
  localparam logic [IDX_W-1:0] COUNT_RST = 4'd13;
  localparam logic [IDX_W-1:0] GBEST_RST = 4'd1;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_PREDICTOR_COUNT = 2'd1,
    CFG_SELECT_MODE     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_ROW0  = 2'd0,
    PH_ROW1  = 2'd1,
    PH_LATER = 2'd2
  } row_phase_e;

  typedef enum logic [IDX_W-1:0] {
    CAND_A   = 4'd0,
    CAND_B   = 4'd1,
    CAND_C   = 4'd2,
    CAND_ABC = 4'd3,
    CAND_D   = 4'd4,
    CAND_AC2 = 4'd5,
    CAND_CB2 = 4'd6,
    CAND_BD2 = 4'd7,
    CAND_AD2 = 4'd8,
    CAND_CD2 = 4'd9,
    CAND_BCD = 4'd10,
    CAND_CBA = 4'd11,
    CAND_ACB = 4'd12
  } cand_e;

  typedef logic signed [PRED_W-1:0] pred_t;

  // 8-bit sample widened to the signed prediction width
  function automatic pred_t ext(input logic [PIX_W-1:0] v);
    return pred_t'({2'b00, v});
  endfunction

  // floor of the mean of two samples
  function automatic pred_t avg(input logic [PIX_W-1:0] u, input logic [PIX_W-1:0] v);
    logic [PIX_W:0] s;
    s = {1'b0, u} + {1'b0, v};
    return pred_t'({2'b00, s[PIX_W:1]});
  endfunction

  // a left, b above, c upper-left, d upper-right
  function automatic pred_t candidate(input logic [IDX_W-1:0] k,
                                      input logic [PIX_W-1:0] a,
                                      input logic [PIX_W-1:0] b,
                                      input logic [PIX_W-1:0] c,
                                      input logic [PIX_W-1:0] d);
    pred_t r;
    unique case (k)
      CAND_A:   r = ext(a);
      CAND_B:   r = ext(b);
      CAND_C:   r = ext(c);
      CAND_ABC: r = ext(a) + ext(b) - ext(c);
      CAND_D:   r = ext(d);
      CAND_AC2: r = avg(a, c);
      CAND_CB2: r = avg(c, b);
      CAND_BD2: r = avg(b, d);
      CAND_AD2: r = avg(a, d);
      CAND_CD2: r = avg(c, d);
      CAND_BCD: r = ext(b) + ext(c) - ext(d);
      CAND_CBA: r = ext(c) + ext(b) - ext(a);
      CAND_ACB: r = ext(a) + ext(c) - ext(b);
      default:  r = '0;
    endcase
    return r;
  endfunction

  // median edge detector
  function automatic pred_t median(input logic [PIX_W-1:0] up,
                                   input logic [PIX_W-1:0] lf,
                                   input logic [PIX_W-1:0] ul);
    pred_t r;
    if (ul > up && ul > lf) begin
      r = (up < lf) ? ext(up) : ext(lf);
    end else if (ul < up && ul < lf) begin
      r = (up > lf) ? ext(up) : ext(lf);
    end else begin
      r = ext(up) + ext(lf) - ext(ul);
    end
    return r;
  endfunction

endpackage

[src/aps_ram.sv]
// Generic RAM: one write port, two registered read ports.
module aps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[src/adaptive_pixel_predictor_select.sv]
// Adaptive pixel predictor select: one word per clock unless stalled, 2-stage pipe, row RAM.
//
// Pixels arrive in raster order. Each one is predicted (nothing on row 0, median
// edge detector on row 1, a stored candidate index later) and then all enabled
// candidates are scored against it; the lowest-error index (lower index on a tie)
// is stored per column or globally, per select_mode. Sustained rate is one pixel
// word per cycle while the output is accepted; a word that is taken goes into the
// stage 1 registers and then into the output register when it leaves stage 1.
// Stage 0 issues the RAM reads, stage 1 forms predictions, runs the 13-lane error
// tree and writes back. The row RAM holds {best index, pixel} per column and has
// two read ports (this column and the one to its right); the pixel and the
// column's best index are written together when the word leaves stage 1, and a
// word read in that same cycle at the same column takes the written data through
// a forwarding register instead. The RAM is not cleared after reset: entries of
// a row that was never written read as garbage, which matters if the width grows
// mid-frame or a stored index is read before a search wrote it. A configuration
// write takes effect at once, so write registers only while the block is idle.
module adaptive_pixel_predictor_select #(
  parameter int MAX_WIDTH       = 4096,
  parameter int PREDICTOR_SLOTS = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [aps_pkg::CFG_W-1:0]       cfg_wdata_i,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [aps_pkg::PIX_W-1:0]       pixel_i,
  input  logic                            frame_start_i,
  // prediction output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [aps_pkg::PRED_W-1:0] prediction_o,
  output logic [aps_pkg::IDX_W-1:0]       predictor_used_o,
  output logic [aps_pkg::IDX_W-1:0]       best_found_o
);

  `include "adaptive_pixel_predictor_select_assert.svh"

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WCW_M  = $clog2(MAX_WIDTH + 1);
  localparam int WCW    = (WCW_M > aps_pkg::CFG_W) ? WCW_M : aps_pkg::CFG_W;
  localparam int LEAVES = 1 << $clog2(PREDICTOR_SLOTS);
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int PW     = aps_pkg::PIX_W;
  localparam int IW     = aps_pkg::IDX_W;

  // ---------------------------------------------------------------- config
  logic [aps_pkg::CFG_W-1:0] cfg_width_q;
  logic [IW-1:0]             cfg_count_q;
  logic                      cfg_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q <= aps_pkg::WIDTH_RST;
      cfg_count_q <= aps_pkg::COUNT_RST;
      cfg_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        aps_pkg::CFG_IMAGE_WIDTH:     cfg_width_q <= cfg_wdata_i;
        aps_pkg::CFG_PREDICTOR_COUNT: cfg_count_q <= cfg_wdata_i[IW-1:0];
        aps_pkg::CFG_SELECT_MODE:     cfg_mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // clamp width to 2..MAX_WIDTH and count to the lanes built
  logic [WCW-1:0] w_raw, w_eff;
  logic [IW-1:0]  n_eff;

  assign w_raw = WCW'(cfg_width_q);
  assign w_eff = (w_raw < WCW'(2)) ? WCW'(2) :
                 (w_raw > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : w_raw;
  assign n_eff = (cfg_count_q > IW'(PREDICTOR_SLOTS)) ? IW'(PREDICTOR_SLOTS) : cfg_count_q;

  // ------------------------------------------------------------ handshakes
  logic s1_valid_q, s1_fire, in_fire, out_valid_q;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------- stage 0: position
  logic [AW-1:0] col_pos_q, col_pos_d;
  logic [1:0]    row_phase_q, row_phase_d;
  logic [AW-1:0] pos0, x0;
  logic [1:0]    ph0, ph_cur;
  logic          wrap0, last0;
  logic [WCW-1:0] x_nxt;

  always_comb begin
    pos0   = frame_start_i ? '0 : col_pos_q;
    ph0    = frame_start_i ? aps_pkg::PH_ROW0 : row_phase_q;
    // width may have shrunk below the stored position
    wrap0  = WCW'(pos0) >= w_eff;
    x0     = wrap0 ? '0 : pos0;
    ph_cur = (wrap0 && ph0 != aps_pkg::PH_LATER) ? ph0 + 2'd1 : ph0;
    x_nxt  = WCW'(x0) + WCW'(1);
    last0  = x_nxt >= w_eff;
    col_pos_d   = last0 ? '0 : x_nxt[AW-1:0];
    row_phase_d = (last0 && ph_cur != aps_pkg::PH_LATER) ? ph_cur + 2'd1 : ph_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q   <= '0;
      row_phase_q <= aps_pkg::PH_ROW0;
    end else if (in_fire) begin
      col_pos_q   <= col_pos_d;
      row_phase_q <= row_phase_d;
    end
  end

  // ---------------------------------------------------------------- row RAM
  logic [AW-1:0]              s1_x_q;
  logic [aps_pkg::WORD_W-1:0] wr_word, wr_word_q, rd_a, rd_b;

  aps_ram #(
    .WIDTH (aps_pkg::WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk_i     (clk_i),
    .we_i      (s1_fire),
    .waddr_i   (s1_x_q),
    .wdata_i   (wr_word),
    .re_i      (in_fire),
    .raddr_a_i (x0),
    .raddr_b_i (x_nxt[AW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // ------------------------------------------------------- stage 1 registers
  logic [PW-1:0] s1_px_q;
  logic [1:0]    s1_phase_q;
  logic          s1_col0_q, s1_last_q, fwd_a_q, fwd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q    <= pixel_i;
      s1_x_q     <= x0;
      s1_phase_q <= ph_cur;
      s1_col0_q  <= (x0 == '0);
      s1_last_q  <= last0;
      // the word leaving stage 1 writes its column as this read happens
      fwd_a_q    <= s1_fire && (s1_x_q == x0);
      fwd_b_q    <= s1_fire && (s1_x_q == x_nxt[AW-1:0]);
    end
    if (s1_fire) begin
      wr_word_q <= wr_word;
    end
  end

  // ------------------------------------------------ stage 1: neighbors
  logic [PW-1:0] left_q, upleft_q;
  logic [IW-1:0] gbest_q;
  logic [PW-1:0] up, ur_raw, nb_a, nb_b, nb_c, nb_d;
  logic [IW-1:0] cb_rd, idx;

  always_comb begin
    up     = fwd_a_q ? wr_word_q[PW-1:0] : rd_a[PW-1:0];
    cb_rd  = fwd_a_q ? wr_word_q[aps_pkg::WORD_W-1:PW] : rd_a[aps_pkg::WORD_W-1:PW];
    ur_raw = fwd_b_q ? wr_word_q[PW-1:0] : rd_b[PW-1:0];
    // edges replicate the pixel above
    nb_b   = up;
    nb_d   = s1_last_q ? up : ur_raw;
    nb_a   = s1_col0_q ? up : left_q;
    nb_c   = s1_col0_q ? up : upleft_q;
    idx    = cfg_mode_q ? gbest_q : cb_rd;
  end

  // ------------------------------------------- stage 1: candidate lanes
  logic [aps_pkg::ERR_W-1:0] tree_err [NODES];
  logic [IW-1:0]             tree_idx [NODES];

  for (genvar k = 0; k < LEAVES; k++) begin : g_lane
    if (k < PREDICTOR_SLOTS) begin : g_real
      aps_pkg::pred_t              cand;
      logic signed [aps_pkg::PRED_W:0] diff;
      logic [aps_pkg::PRED_W:0]        mag;

      always_comb begin
        cand = aps_pkg::candidate(IW'(k), nb_a, nb_b, nb_c, nb_d);
        diff = $signed({3'b000, s1_px_q}) - $signed({cand[aps_pkg::PRED_W-1], cand});
        mag  = diff[aps_pkg::PRED_W] ? $unsigned(-diff) : $unsigned(diff);
      end

      assign tree_err[LEAVES-1+k] = (IW'(k) < n_eff) ? mag[aps_pkg::ERR_W-1:0]
                                                     : aps_pkg::ERR_INIT;
      assign tree_idx[LEAVES-1+k] = IW'(k);
    end else begin : g_pad
      assign tree_err[LEAVES-1+k] = aps_pkg::ERR_INIT;
      assign tree_idx[LEAVES-1+k] = IW'(k);
    end
  end

  // min tree; left child holds lower indices and wins ties
  for (genvar i = 0; i < LEAVES - 1; i++) begin : g_node
    logic take_r;
    assign take_r      = tree_err[2*i+2] < tree_err[2*i+1];
    assign tree_err[i] = take_r ? tree_err[2*i+2] : tree_err[2*i+1];
    assign tree_idx[i] = take_r ? tree_idx[2*i+2] : tree_idx[2*i+1];
  end

  // --------------------------------------------- stage 1: result forming
  aps_pkg::pred_t pred;
  logic [IW-1:0]  used, best, best_srch, cb_new;
  logic           predicted;

  always_comb begin
    predicted = (s1_phase_q != aps_pkg::PH_ROW0);
    // no candidate tested keeps the stored index
    best_srch = (tree_err[0] == aps_pkg::ERR_INIT) ? idx : tree_idx[0];
    priority if (s1_phase_q == aps_pkg::PH_ROW0) begin
      pred = '0;
      used = aps_pkg::USED_NONE;
      best = '0;
    end else if (s1_phase_q == aps_pkg::PH_ROW1) begin
      pred = aps_pkg::median(nb_b, nb_a, nb_c);
      used = aps_pkg::USED_MEDIAN;
      best = best_srch;
    end else begin
      pred = (idx < n_eff) ? aps_pkg::candidate(idx, nb_a, nb_b, nb_c, nb_d) : '1;
      used = idx;
      best = best_srch;
    end
    cb_new  = (predicted && !cfg_mode_q) ? best : cb_rd;
    wr_word = {cb_new, s1_px_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      upleft_q <= '0;
      gbest_q  <= aps_pkg::GBEST_RST;
    end else if (s1_fire) begin
      left_q   <= s1_px_q;
      upleft_q <= up;
      if (predicted && cfg_mode_q) begin
        gbest_q <= best;
      end
    end
  end

  // -------------------------------------------------------- output register
  logic signed [aps_pkg::PRED_W-1:0] pred_q;
  logic [IW-1:0]                     used_q, best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pred_q <= pred;
      used_q <= used;
      best_q <= best;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign prediction_o     = pred_q;
  assign predictor_used_o = used_q;
  assign best_found_o     = best_q;

  // -------------------------------------------------------------- checks
  `APS_ASSERT(a_s1_to_out, s1_fire |=> out_valid_o)
  `APS_ASSERT(a_row0_result,
              (out_valid_o && predictor_used_o == aps_pkg::USED_NONE)
              |-> (prediction_o == '0 && best_found_o == '0))
  `APS_ASSERT(a_fwd_needs_word,
              (fwd_a_q || fwd_b_q) && s1_valid_q |-> !$past(in_fire) || $past(s1_valid_q))
  `APS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!out_valid_o && !s1_valid_q))

endmodule

[tb/tb_adaptive_pixel_predictor_select.sv]
// Self-checking testbench for the adaptive pixel predictor select block.
`timescale 1ns / 1ps

module tb_adaptive_pixel_predictor_select;

  localparam int MAX_W        = 4096;
  localparam int SLOTS        = 13;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 4;    // pipe is two deep, give it a little extra
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;
  localparam int LONG_HOLD    = 150;  // receiver stall long enough to back up the pipe
  localparam int TARGET_PIX   = 650;

  // Directed frame at width 3: rows of extremes so the linear candidates hit
  // both ends of the signed prediction range, then a restart in the middle of a row.
  localparam int DIR_N = 14;
  localparam logic [7:0] DIR_PX [DIR_N] = '{
    8'd0,   8'd255, 8'd0,
    8'd255, 8'd0,   8'd255,
    8'd255, 8'd255, 8'd0,
    8'd0,   8'd0,   8'd255,
    8'd128, 8'd1
  };
  localparam bit DIR_FS [DIR_N] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};

  // Fixed register plan: width clamps (0 and 8191), count clamps (14, 15), count
  // zero, stored index above the count, both select modes, shrink in mid-row.
  localparam int PLAN_N = 13;
  localparam int PLAN_W     [PLAN_N] = '{5, 2, 7, 7, 6, 6, 16, 8191, 0, 12, 3, 4096, 10};
  localparam int PLAN_CNT   [PLAN_N] = '{13, 13, 5, 0, 1, 0, 15, 14, 13, 13, 9, 13, 3};
  localparam int PLAN_MODE  [PLAN_N] = '{0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 1, 0};
  localparam int PLAN_ITEMS [PLAN_N] = '{60, 40, 50, 30, 50, 30, 80, 12, 40, 45, 40, 10, 40};
  localparam int PLAN_HOLD  = 6;      // plan entry that carries the long receiver stall

  typedef struct packed {
    logic signed [aps_pkg::PRED_W-1:0] prediction;
    logic [aps_pkg::IDX_W-1:0]         used;
    logic [aps_pkg::IDX_W-1:0]         best;
  } pred_word_t;

  // Tracks the block's row memory and selection state, predicts each output
  // word and checks the words that come back in order.
  class pred_tracker;
    int unsigned               width_reg;
    int unsigned               count_reg;
    bit                        mode_reg;
    logic [aps_pkg::PIX_W-1:0] above_row [MAX_W];
    logic [aps_pkg::IDX_W-1:0] col_best  [MAX_W];
    bit                        above_set [MAX_W];
    bit                        best_set  [MAX_W];
    logic [aps_pkg::PIX_W-1:0] left_px;
    logic [aps_pkg::PIX_W-1:0] upleft_px;
    logic [aps_pkg::IDX_W-1:0] global_best;
    int unsigned               col;
    aps_pkg::row_phase_e       phase;
    pred_word_t                pending[$];
    int unsigned               mismatches;
    int unsigned               checked;
    int unsigned               none_cnt;
    int unsigned               median_cnt;
    int unsigned               untested_cnt;

    function new();
      width_reg    = aps_pkg::WIDTH_RST;
      count_reg    = aps_pkg::COUNT_RST;
      mode_reg     = 1'b0;
      left_px      = '0;
      upleft_px    = '0;
      global_best  = aps_pkg::GBEST_RST;
      col          = 0;
      phase        = aps_pkg::PH_ROW0;
      mismatches   = 0;
      checked      = 0;
      none_cnt     = 0;
      median_cnt   = 0;
      untested_cnt = 0;
    endfunction

    function int eff_width();
      if (width_reg < 2) return 2;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int eff_count();
      return (count_reg > SLOTS) ? SLOTS : count_reg;
    endfunction

    function void write_reg(aps_pkg::cfg_idx_e idx, logic [aps_pkg::CFG_W-1:0] val);
      case (idx)
        aps_pkg::CFG_IMAGE_WIDTH:     width_reg = val;
        aps_pkg::CFG_PREDICTOR_COUNT: count_reg = val[aps_pkg::IDX_W-1:0];
        aps_pkg::CFG_SELECT_MODE:     mode_reg  = val[0];
        default: ;
      endcase
    endfunction

    function void next_row();
      col = 0;
      if (phase == aps_pkg::PH_ROW0) phase = aps_pkg::PH_ROW1;
      else phase = aps_pkg::PH_LATER;
    endfunction

    // a left, b above, c upper-left, d upper-right; halves round down
    function int cand_value(logic [aps_pkg::IDX_W-1:0] k, int a, int b, int c, int d);
      case (k)
        aps_pkg::CAND_A:   return a;
        aps_pkg::CAND_B:   return b;
        aps_pkg::CAND_C:   return c;
        aps_pkg::CAND_ABC: return a + b - c;
        aps_pkg::CAND_D:   return d;
        aps_pkg::CAND_AC2: return (a + c) / 2;
        aps_pkg::CAND_CB2: return (c + b) / 2;
        aps_pkg::CAND_BD2: return (b + d) / 2;
        aps_pkg::CAND_AD2: return (a + d) / 2;
        aps_pkg::CAND_CD2: return (c + d) / 2;
        aps_pkg::CAND_BCD: return b + c - d;
        aps_pkg::CAND_CBA: return c + b - a;
        aps_pkg::CAND_ACB: return a + c - b;
        default:           return 0;
      endcase
    endfunction

    function int med_edge(int up, int lf, int ul);
      if (ul > up && ul > lf) return (up < lf) ? up : lf;
      if (ul < up && ul < lf) return (up > lf) ? up : lf;
      return up + lf - ul;
    endfunction

    // True if a plain pixel now would read row memory that was never written.
    function bit restart_needed();
      int                  w;
      int                  x;
      aps_pkg::row_phase_e ph;
      w  = eff_width();
      x  = col;
      ph = phase;
      if (x >= w) begin
        x = 0;
        if (ph == aps_pkg::PH_ROW0) ph = aps_pkg::PH_ROW1;
        else ph = aps_pkg::PH_LATER;
      end
      if (ph == aps_pkg::PH_ROW0) return 1'b0;
      if (!above_set[x]) return 1'b1;
      if (x + 1 < w && !above_set[x + 1]) return 1'b1;
      if (!mode_reg && (ph == aps_pkg::PH_LATER || eff_count() == 0) && !best_set[x])
        return 1'b1;
      return 1'b0;
    endfunction

    function void note_pixel(logic [aps_pkg::PIX_W-1:0] px, logic fs);
      int                        w;
      int                        n;
      int                        x;
      int                        k;
      int                        pv;
      int                        a;
      int                        b;
      int                        c;
      int                        d;
      int                        pred;
      int                        err;
      int                        best_err;
      logic [aps_pkg::IDX_W-1:0] sel;
      logic [aps_pkg::IDX_W-1:0] used;
      logic [aps_pkg::IDX_W-1:0] best;
      logic [aps_pkg::PIX_W-1:0] up;
      logic [aps_pkg::PIX_W-1:0] ur;
      pred_word_t                want;
      w  = eff_width();
      n  = eff_count();
      pv = px;
      if (fs) begin
        col   = 0;
        phase = aps_pkg::PH_ROW0;
      end
      if (col >= w) next_row();    // width shrank under a running row
      x    = col;
      up   = above_row[x];
      ur   = (x + 1 < w) ? above_row[x + 1] : up;
      pred = 0;
      used = aps_pkg::USED_NONE;
      best = '0;
      if (phase != aps_pkg::PH_ROW0) begin
        b = up;
        if (x == 0) begin
          a = b;
          c = b;
          d = ur;
        end else begin
          a = left_px;
          c = upleft_px;
          d = (x == w - 1) ? b : ur;
        end
        sel = mode_reg ? global_best : col_best[x];
        if (phase == aps_pkg::PH_ROW1) begin
          pred = (x == 0) ? int'(up) : med_edge(up, left_px, upleft_px);
          used = aps_pkg::USED_MEDIAN;
          median_cnt++;
        end else begin
          if (sel < n) begin
            pred = cand_value(sel, a, b, c, d);
          end else begin
            pred = -1;
            untested_cnt++;
          end
          used = sel;
        end
        // lowest error wins, strict compare keeps the lower index on a tie
        best     = sel;
        best_err = aps_pkg::ERR_INIT;
        for (k = 0; k < n; k++) begin
          err = pv - cand_value(k[aps_pkg::IDX_W-1:0], a, b, c, d);
          if (err < 0) err = -err;
          if (err < best_err) begin
            best_err = err;
            best     = k[aps_pkg::IDX_W-1:0];
          end
        end
        if (mode_reg) begin
          global_best = best;
        end else begin
          col_best[x] = best;
          best_set[x] = 1'b1;
        end
      end else begin
        none_cnt++;
      end
      upleft_px    = up;
      above_row[x] = px;
      above_set[x] = 1'b1;
      left_px      = px;
      col          = x + 1;
      if (col >= w) next_row();
      want.prediction = pred[aps_pkg::PRED_W-1:0];
      want.used       = used;
      want.best       = best;
      pending.push_back(want);
    endfunction

    function void check_word(logic signed [aps_pkg::PRED_W-1:0] p,
                             logic [aps_pkg::IDX_W-1:0] u,
                             logic [aps_pkg::IDX_W-1:0] b);
      pred_word_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected word: prediction %0d used %0d best %0d", p, u, b);
        return;
      end
      want = pending.pop_front();
      if (p !== want.prediction || u !== want.used || b !== want.best) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("word %0d: expected pred %0d used %0d best %0d, got pred %0d used %0d best %0d",
                   checked, want.prediction, want.used, want.best, p, u, b);
      end
    endfunction
  endclass

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              cfg_we_i      = 1'b0;
  logic [1:0]                        cfg_index_i   = '0;
  logic [aps_pkg::CFG_W-1:0]         cfg_wdata_i   = '0;
  logic                              in_valid_i    = 1'b0;
  logic                              in_ready_o;
  logic [aps_pkg::PIX_W-1:0]         pixel_i       = '0;
  logic                              frame_start_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_ready_i   = 1'b0;
  logic signed [aps_pkg::PRED_W-1:0] prediction_o;
  logic [aps_pkg::IDX_W-1:0]         predictor_used_o;
  logic [aps_pkg::IDX_W-1:0]         best_found_o;

  pred_tracker  board;
  int unsigned  cycle_cnt   = 0;
  int unsigned  pixels_sent = 0;
  int unsigned  frames_sent = 0;
  int unsigned  cfg_writes  = 0;
  bit           long_hold_req = 1'b0;
  bit           sender_burst  = 1'b0;
  int           frame_left    = 0;
  logic [7:0]   last_px       = '0;

  adaptive_pixel_predictor_select dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_i          (pixel_i),
    .frame_start_i    (frame_start_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .prediction_o     (prediction_o),
    .predictor_used_o (predictor_used_o),
    .best_found_o     (best_found_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a lost word or a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d words still pending",
               cycle_cnt, board.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: every accepted word is checked against the oldest prediction.
  // Ready drops for a random stall after each word, except in bursts of full rate
  // and one long hold that lets the pipe fill and stall the input.
  initial begin : result_side
    int stall;
    bit burst;
    stall = 0;
    burst = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        board.check_word(prediction_o, predictor_used_o, best_found_o);
        stall = burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 31) == 0) burst = !burst;
      end
      if (long_hold_req) begin
        stall         = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Register write; caller makes sure nothing is in flight and drops the enable.
  task automatic write_cfg(aps_pkg::cfg_idx_e idx, logic [aps_pkg::CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    board.write_reg(idx, val);
    @(posedge clk_i);
    cfg_writes++;
  endtask

  // Drop valid and let every predicted word come back before touching registers.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Offer one pixel word after a random gap and hold it until taken.
  task automatic send_pixel(logic [7:0] px, logic fs);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= px;
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pixel(px, fs);
    pixels_sent++;
    if (fs) frames_sent++;
  endtask

  // Mostly smooth content so that different predictors win, with extremes and noise.
  function automatic logic [7:0] draw_pixel();
    int r;
    int v;
    r = $urandom_range(0, 15);
    if (r == 0) v = 0;
    else if (r == 1) v = 255;
    else if (r < 6) v = $urandom_range(0, 255);
    else begin
      v = int'(last_px) + int'($urandom_range(0, 16)) - 8;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
    end
    last_px = v[7:0];
    return v[7:0];
  endfunction

  // Whole frames of a few rows, the odd stray frame start to break one off,
  // and a forced restart wherever the row memory would be read unwritten.
  task automatic send_frames(int count, int hold_at);
    int   i;
    int   w;
    logic fs;
    for (i = 0; i < count; i++) begin
      if (i == hold_at) long_hold_req = 1'b1;
      w  = board.eff_width();
      fs = (frame_left <= 0 || $urandom_range(0, 39) == 0);
      if (!fs && board.restart_needed()) fs = 1'b1;
      if (fs) begin
        frame_left = w * int'($urandom_range(2, 5));
        if ($urandom_range(0, 3) == 0) frame_left += int'($urandom_range(1, w));
      end
      send_pixel(draw_pixel(), fs);
      frame_left--;
      if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
    end
  endtask

  task automatic load_regs(int w, int n, int m);
    wait_idle();
    write_cfg(aps_pkg::CFG_IMAGE_WIDTH, aps_pkg::CFG_W'(w));
    write_cfg(aps_pkg::CFG_PREDICTOR_COUNT, aps_pkg::CFG_W'(n));
    write_cfg(aps_pkg::CFG_SELECT_MODE, aps_pkg::CFG_W'(m));
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int p;
    int w;
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frame at width 3 with every prediction mode and a mid-row restart
    load_regs(3, 13, 0);
    for (p = 0; p < DIR_N; p++) send_pixel(DIR_PX[p], DIR_FS[p]);

    // fixed plan, frames continue across register changes
    for (p = 0; p < PLAN_N; p++) begin
      load_regs(PLAN_W[p], PLAN_CNT[p], PLAN_MODE[p]);
      send_frames(PLAN_ITEMS[p], (p == PLAN_HOLD) ? 10 : -1);
    end

    // random settings, mostly narrow images
    while (pixels_sent < TARGET_PIX) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
      load_regs(w, $urandom_range(0, 15), $urandom_range(0, 1));
      send_frames($urandom_range(20, 40), -1);
    end

    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d pixels in %0d frames, %0d register writes, %0d words checked, %0d mismatches",
             pixels_sent, frames_sent, cfg_writes, board.checked, board.mismatches);
    $display("row zero %0d, median %0d, stored index not tested %0d",
             board.none_cnt, board.median_cnt, board.untested_cnt);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
